// ----- hw/rtl/rpch_pkg.sv -----
// Shared types and constants of the ray / parabolic cylinder intersection block
`timescale 1ns / 1ps
package rpch_pkg;

	localparam int ROOT_STEPS  = 64;   // digits of the discriminant square root
	localparam int DIV_STEPS   = 32;   // quotient bits of the path length divide
	localparam int NROOT_STEPS = 32;   // digits of the normal length square root
	localparam int NDIV_STEPS  = 31;   // quotient bits of the normal divides

	localparam logic [30:0] FOCAL_RESET = 31'd65536;
	localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		FAULT_OK       = 2'd0,
		FAULT_NEG_DISC = 2'd1,
		FAULT_NO_ROOT  = 2'd2
	} fault_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
	} ray_t;

	// quadratic coefficients as sign and magnitude: h = B/2, C, A
	typedef struct packed {
		ray_t        ray;
		logic [30:0] p;
		logic [63:0] hmag;
		logic        hneg;
		logic [63:0] cmag;
		logic        cneg;
		logic [62:0] amag;
		fault_t      fault;
	} coef_t;

	typedef struct packed {
		logic signed [31:0] t;
		logic signed [31:0] hx;
		logic signed [31:0] hy;
		logic signed [31:0] hz;
		logic [30:0]        p;
		fault_t             fault;
	} hit_t;

	typedef struct packed {
		logic signed [31:0] t;
		logic signed [31:0] hx;
		logic signed [31:0] hy;
		logic signed [31:0] hz;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		fault_t             fault;
	} res_t;

endpackage

// ----- hw/rtl/rpch_ray_if.sv -----
// Ray input channel: valid, ready and origin / direction payload
`timescale 1ns / 1ps
interface rpch_ray_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] origin_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;

	modport source (
		output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input  ready
	);
	modport sink (
		input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready
	);
endinterface

// ----- hw/rtl/rpch_hit_if.sv -----
// Hit result channel: valid, ready and path length, hit point, normal, fault
`timescale 1ns / 1ps
interface rpch_hit_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] path_len;
	logic signed [31:0] hit_x;
	logic signed [31:0] hit_y;
	logic signed [31:0] hit_z;
	logic signed [31:0] normal_y;
	logic signed [31:0] normal_z;
	logic [1:0]         fault;

	modport source (
		output valid, path_len, hit_x, hit_y, hit_z, normal_y, normal_z, fault,
		input  ready
	);
	modport sink (
		input  valid, path_len, hit_x, hit_y, hit_z, normal_y, normal_z, fault,
		output ready
	);
endinterface

// ----- hw/rtl/rpch_coef.sv -----
// Coefficient front end: A, B/2, C and the discriminant, six stages
`timescale 1ns / 1ps
module rpch_coef (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  rpch_pkg::ray_t  in_ray,
	input  logic [30:0]     in_p,
	output logic            out_valid,
	output rpch_pkg::coef_t out_coef,
	output logic [127:0]    out_disc
);
	import rpch_pkg::*;

	logic [5:0] v_s;

	// stage 1: products
	ray_t               ray_s1;
	logic [30:0]        p_s1;
	logic signed [63:0] pdz_s1, pdyoy_s1, poy2_s1, ppoz_s1, a_s1;
	// stage 2: sums
	ray_t               ray_s2;
	logic [30:0]        p_s2;
	logic signed [64:0] h_s2;
	logic signed [65:0] c_s2;
	logic [62:0]        a_s2;
	// stages 3..6
	coef_t              cf_s3, cf_s4, cf_s5, cf_s6;
	logic [63:0]        hh00_s4, hh01_s4, hh11_s4, ac00_s4, ac01_s4, ac10_s4, ac11_s4;
	logic [127:0]       hh_s5, ac_s5, disc_s6;

	logic [127:0] sum_w;
	logic [128:0] diff_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[4:0], in_valid};
		end
	end

	assign sum_w  = hh_s5 + ac_s5;
	assign diff_w = {1'b0, hh_s5} - {1'b0, ac_s5};

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s1   <= in_ray;
			p_s1     <= in_p;
			pdz_s1   <= in_ray.dz * $signed({1'b0, in_p});
			pdyoy_s1 <= in_ray.dy * in_ray.oy;
			poy2_s1  <= in_ray.oy * in_ray.oy;
			ppoz_s1  <= in_ray.oz * $signed({1'b0, in_p});
			a_s1     <= in_ray.dy * in_ray.dy;

			ray_s2 <= ray_s1;
			p_s2   <= p_s1;
			h_s2   <= 65'(pdz_s1) + 65'(pdyoy_s1);
			c_s2   <= 66'(poy2_s1) + (66'(ppoz_s1) <<< 1);
			a_s2   <= a_s1[62:0];

			cf_s3.ray   <= ray_s2;
			cf_s3.p     <= p_s2;
			cf_s3.hneg  <= h_s2[64];
			cf_s3.hmag  <= h_s2[64] ? 64'(-h_s2) : h_s2[63:0];
			cf_s3.cneg  <= c_s2[65];
			cf_s3.cmag  <= c_s2[65] ? 64'(-c_s2) : c_s2[63:0];
			cf_s3.amag  <= a_s2;
			cf_s3.fault <= FAULT_OK;

			// 32 x 32 partial products of h*h and A*C
			cf_s4   <= cf_s3;
			hh00_s4 <= cf_s3.hmag[31:0] * cf_s3.hmag[31:0];
			hh01_s4 <= cf_s3.hmag[31:0] * cf_s3.hmag[63:32];
			hh11_s4 <= cf_s3.hmag[63:32] * cf_s3.hmag[63:32];
			ac00_s4 <= cf_s3.amag[31:0] * cf_s3.cmag[31:0];
			ac01_s4 <= cf_s3.amag[31:0] * cf_s3.cmag[63:32];
			ac10_s4 <= cf_s3.amag[62:32] * cf_s3.cmag[31:0];
			ac11_s4 <= cf_s3.amag[62:32] * cf_s3.cmag[63:32];

			cf_s5 <= cf_s4;
			hh_s5 <= {hh11_s4, hh00_s4} + {31'd0, hh01_s4, 33'd0};
			ac_s5 <= {ac11_s4, ac00_s4} + {32'd0, ac01_s4, 32'd0}
				+ {32'd0, ac10_s4, 32'd0};

			cf_s6.ray  <= cf_s5.ray;
			cf_s6.p    <= cf_s5.p;
			cf_s6.hmag <= cf_s5.hmag;
			cf_s6.hneg <= cf_s5.hneg;
			cf_s6.cmag <= cf_s5.cmag;
			cf_s6.cneg <= cf_s5.cneg;
			cf_s6.amag <= cf_s5.amag;
			disc_s6    <= cf_s5.cneg ? sum_w : diff_w[127:0];
			if (cf_s5.amag == '0) begin
				cf_s6.fault <= (cf_s5.hmag == '0) ? FAULT_NO_ROOT : FAULT_OK;
			end else begin
				cf_s6.fault <= (!cf_s5.cneg && diff_w[128]) ? FAULT_NEG_DISC : FAULT_OK;
			end
		end
	end

	assign out_valid = v_s[5];
	assign out_coef  = cf_s6;
	assign out_disc  = disc_s6;

endmodule

// ----- hw/rtl/rpch_root.sv -----
// Discriminant square root: one result bit per stage over 64 stages
`timescale 1ns / 1ps
module rpch_root (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  rpch_pkg::coef_t in_coef,
	input  logic [127:0]    in_disc,
	output logic            out_valid,
	output rpch_pkg::coef_t out_coef,
	output logic [63:0]     out_root
);
	import rpch_pkg::*;

	logic [ROOT_STEPS-1:0] v_s;
	logic [64:0]           rem_s [ROOT_STEPS];
	logic [63:0]           res_s [ROOT_STEPS];
	logic [127:0]          rad_s [ROOT_STEPS];
	coef_t                 cf_s  [ROOT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[ROOT_STEPS-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
		logic [64:0]  rem_in;
		logic [63:0]  res_in;
		logic [127:0] rad_in;
		coef_t        cf_in;
		logic [66:0]  cur, trial;

		if (k == 0) begin : g_head
			assign rem_in = '0;
			assign res_in = '0;
			assign rad_in = in_disc;
			assign cf_in  = in_coef;
		end else begin : g_body
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
			assign rad_in = rad_s[k-1];
			assign cf_in  = cf_s[k-1];
		end

		// bring down two radicand bits, try the next root bit
		assign cur   = {rem_in, rad_in[127:126]};
		assign trial = {1'b0, res_in, 2'b01};

		always_ff @(posedge clk) begin
			if (adv) begin
				if (cur >= trial) begin
					rem_s[k] <= 65'(cur - trial);
					res_s[k] <= {res_in[62:0], 1'b1};
				end else begin
					rem_s[k] <= cur[64:0];
					res_s[k] <= {res_in[62:0], 1'b0};
				end
				rad_s[k] <= {rad_in[125:0], 2'b00};
				cf_s[k]  <= cf_in;
			end
		end
	end

	assign out_valid = v_s[ROOT_STEPS-1];
	assign out_coef  = cf_s[ROOT_STEPS-1];
	assign out_root  = res_s[ROOT_STEPS-1];

endmodule

// ----- hw/rtl/rpch_path.sv -----
// Path length divide, saturation and hit point, 36 stages
`timescale 1ns / 1ps
module rpch_path (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  rpch_pkg::coef_t in_coef,
	input  logic [63:0]     in_root,
	output logic            out_valid,
	output rpch_pkg::hit_t  out_hit
);
	import rpch_pkg::*;

	localparam int NSTG = DIV_STEPS + 4;

	typedef struct packed {
		ray_t        ray;
		logic [30:0] p;
		fault_t      fault;
		logic        tneg;
		logic        big;
		logic [63:0] den;
	} dside_t;

	typedef struct packed {
		ray_t        ray;
		logic [30:0] p;
		fault_t      fault;
	} pside_t;

	logic [NSTG-1:0] v_s;

	logic [94:0] num_s1;
	dside_t      sd_s1;

	logic [63:0] rem_s [DIV_STEPS];
	logic [31:0] lo_s  [DIV_STEPS];
	logic [31:0] q_s   [DIV_STEPS];
	dside_t      sd_s  [DIV_STEPS];

	logic signed [31:0] t_s34;
	pside_t             ps_s34;
	logic signed [31:0] t_s35;
	logic signed [63:0] px_s35, py_s35, pz_s35;
	pside_t             ps_s35;
	hit_t               hit_s36;

	logic        lin_w;
	logic [64:0] m_w;
	logic        qneg_w;
	logic [31:0] qf_w;
	dside_t      sdf_w;
	logic signed [31:0] t_w;

	function automatic logic signed [31:0] sat_hit(logic signed [31:0] o,
		logic signed [63:0] pr);
		logic signed [34:0] s;
		s = 35'(o) + 35'(pr >>> 30);
		if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111) begin
			return s[31:0];
		end
		return s[34] ? INT32_MIN : INT32_MAX;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NSTG-2:0], in_valid};
		end
	end

	// select linear or quadratic numerator and divisor
	always_comb begin
		lin_w = (in_coef.amag == '0);
		if (in_coef.hneg) begin
			m_w    = {1'b0, in_root} + {1'b0, in_coef.hmag};
			qneg_w = 1'b0;
		end else if (in_root >= in_coef.hmag) begin
			m_w    = {1'b0, in_root - in_coef.hmag};
			qneg_w = 1'b0;
		end else begin
			m_w    = {1'b0, in_coef.hmag - in_root};
			qneg_w = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1      <= lin_w ? {2'b00, in_coef.cmag, 29'd0} : {m_w, 30'd0};
			sd_s1.ray   <= in_coef.ray;
			sd_s1.p     <= in_coef.p;
			sd_s1.fault <= in_coef.fault;
			sd_s1.tneg  <= lin_w ? (in_coef.cneg == in_coef.hneg) : qneg_w;
			sd_s1.big   <= 1'b0;
			sd_s1.den   <= lin_w ? in_coef.hmag : {1'b0, in_coef.amag};
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [63:0] rem_in;
		logic [31:0] lo_in, q_in;
		dside_t      sd_in;
		logic [64:0] rem2;
		logic        ge;

		if (k == 0) begin : g_head
			// a quotient of 2^32 or more saturates; flag it up front
			always_comb begin
				rem_in = {1'b0, num_s1[94:32]};
				lo_in  = num_s1[31:0];
				q_in   = '0;
				sd_in  = sd_s1;
				sd_in.big = ({1'b0, num_s1[94:32]} >= sd_s1.den);
			end
		end else begin : g_body
			assign rem_in = rem_s[k-1];
			assign lo_in  = lo_s[k-1];
			assign q_in   = q_s[k-1];
			assign sd_in  = sd_s[k-1];
		end

		assign rem2 = {rem_in, lo_in[31]};
		assign ge   = (rem2 >= {1'b0, sd_in.den});

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= ge ? 64'(rem2 - {1'b0, sd_in.den}) : rem2[63:0];
				lo_s[k]  <= {lo_in[30:0], 1'b0};
				q_s[k]   <= {q_in[30:0], ge};
				sd_s[k]  <= sd_in;
			end
		end
	end

	// clamp the signed quotient to int32
	always_comb begin
		qf_w  = q_s[DIV_STEPS-1];
		sdf_w = sd_s[DIV_STEPS-1];
		if (sdf_w.big) begin
			t_w = sdf_w.tneg ? INT32_MIN : INT32_MAX;
		end else if (sdf_w.tneg) begin
			t_w = qf_w[31] ? INT32_MIN : $signed(32'(-qf_w));
		end else begin
			t_w = qf_w[31] ? INT32_MAX : $signed(qf_w);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s34        <= t_w;
			ps_s34.ray   <= sdf_w.ray;
			ps_s34.p     <= sdf_w.p;
			ps_s34.fault <= sdf_w.fault;

			t_s35  <= t_s34;
			ps_s35 <= ps_s34;
			px_s35 <= t_s34 * ps_s34.ray.dx;
			py_s35 <= t_s34 * ps_s34.ray.dy;
			pz_s35 <= t_s34 * ps_s34.ray.dz;

			hit_s36.t     <= t_s35;
			hit_s36.hx    <= sat_hit(ps_s35.ray.ox, px_s35);
			hit_s36.hy    <= sat_hit(ps_s35.ray.oy, py_s35);
			hit_s36.hz    <= sat_hit(ps_s35.ray.oz, pz_s35);
			hit_s36.p     <= ps_s35.p;
			hit_s36.fault <= ps_s35.fault;
		end
	end

	assign out_valid = v_s[NSTG-1];
	assign out_hit   = hit_s36;

endmodule

// ----- hw/rtl/rpch_norm.sv -----
// Surface normal: length square root, two divides and result gating
`timescale 1ns / 1ps
module rpch_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  rpch_pkg::hit_t in_hit,
	output logic           out_valid,
	output rpch_pkg::res_t out_res
);
	import rpch_pkg::*;

	localparam int NSTG = NROOT_STEPS + NDIV_STEPS + 3;

	typedef struct packed {
		hit_t        hit;
		logic [31:0] hyabs;
	} nside_t;

	logic [NSTG-1:0] v_s;

	logic [62:0] sq_s1;
	logic [61:0] pp_s1;
	nside_t      ns_s1;
	logic [63:0] rad_s2;
	nside_t      ns_s2;

	logic [32:0] rem_s [NROOT_STEPS];
	logic [31:0] res_s [NROOT_STEPS];
	logic [63:0] rad_s [NROOT_STEPS];
	nside_t      ns_s  [NROOT_STEPS];

	logic [31:0] ry_s  [NDIV_STEPS];
	logic [30:0] ly_s  [NDIV_STEPS];
	logic [30:0] qy_s  [NDIV_STEPS];
	logic [31:0] rp_s  [NDIV_STEPS];
	logic [30:0] lp_s  [NDIV_STEPS];
	logic [30:0] qp_s  [NDIV_STEPS];
	logic [31:0] root_s [NDIV_STEPS];
	nside_t      nd_s  [NDIV_STEPS];

	res_t res_s66;
	nside_t nf_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NSTG-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1       <= 63'(in_hit.hy * in_hit.hy);
			pp_s1       <= in_hit.p * in_hit.p;
			ns_s1.hit   <= in_hit;
			ns_s1.hyabs <= in_hit.hy[31] ? 32'(-in_hit.hy) : in_hit.hy;

			rad_s2 <= {1'b0, sq_s1} + {2'b00, pp_s1};
			ns_s2  <= ns_s1;
		end
	end

	for (genvar k = 0; k < NROOT_STEPS; k++) begin : g_root
		logic [32:0] rem_in;
		logic [31:0] res_in;
		logic [63:0] rad_in;
		nside_t      ns_in;
		logic [34:0] cur, trial;

		if (k == 0) begin : g_head
			assign rem_in = '0;
			assign res_in = '0;
			assign rad_in = rad_s2;
			assign ns_in  = ns_s2;
		end else begin : g_body
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
			assign rad_in = rad_s[k-1];
			assign ns_in  = ns_s[k-1];
		end

		assign cur   = {rem_in, rad_in[63:62]};
		assign trial = {1'b0, res_in, 2'b01};

		always_ff @(posedge clk) begin
			if (adv) begin
				if (cur >= trial) begin
					rem_s[k] <= 33'(cur - trial);
					res_s[k] <= {res_in[30:0], 1'b1};
				end else begin
					rem_s[k] <= cur[32:0];
					res_s[k] <= {res_in[30:0], 1'b0};
				end
				rad_s[k] <= {rad_in[61:0], 2'b00};
				ns_s[k]  <= ns_in;
			end
		end
	end

	// |y| * 2^30 / root and p * 2^30 / root, both below 2^31
	for (genvar j = 0; j < NDIV_STEPS; j++) begin : g_div
		logic [31:0] ry_in, rp_in, root_in;
		logic [30:0] ly_in, lp_in, qy_in, qp_in;
		nside_t      nd_in;
		logic [32:0] ry2, rp2;
		logic        gey, gep;

		if (j == 0) begin : g_head
			assign ry_in   = {1'b0, ns_s[NROOT_STEPS-1].hyabs[31:1]};
			assign ly_in   = {ns_s[NROOT_STEPS-1].hyabs[0], 30'd0};
			assign rp_in   = {2'b00, ns_s[NROOT_STEPS-1].hit.p[30:1]};
			assign lp_in   = {ns_s[NROOT_STEPS-1].hit.p[0], 30'd0};
			assign qy_in   = '0;
			assign qp_in   = '0;
			assign root_in = res_s[NROOT_STEPS-1];
			assign nd_in   = ns_s[NROOT_STEPS-1];
		end else begin : g_body
			assign ry_in   = ry_s[j-1];
			assign ly_in   = ly_s[j-1];
			assign rp_in   = rp_s[j-1];
			assign lp_in   = lp_s[j-1];
			assign qy_in   = qy_s[j-1];
			assign qp_in   = qp_s[j-1];
			assign root_in = root_s[j-1];
			assign nd_in   = nd_s[j-1];
		end

		assign ry2 = {ry_in, ly_in[30]};
		assign rp2 = {rp_in, lp_in[30]};
		assign gey = (ry2 >= {1'b0, root_in});
		assign gep = (rp2 >= {1'b0, root_in});

		always_ff @(posedge clk) begin
			if (adv) begin
				ry_s[j]   <= gey ? 32'(ry2 - {1'b0, root_in}) : ry2[31:0];
				rp_s[j]   <= gep ? 32'(rp2 - {1'b0, root_in}) : rp2[31:0];
				ly_s[j]   <= {ly_in[29:0], 1'b0};
				lp_s[j]   <= {lp_in[29:0], 1'b0};
				qy_s[j]   <= {qy_in[29:0], gey};
				qp_s[j]   <= {qp_in[29:0], gep};
				root_s[j] <= root_in;
				nd_s[j]   <= nd_in;
			end
		end
	end

	assign nf_w = nd_s[NDIV_STEPS-1];

	// sign the normal, drop everything on a fault
	always_ff @(posedge clk) begin
		if (adv) begin
			if (nf_w.hit.fault != FAULT_OK) begin
				res_s66.t     <= '0;
				res_s66.hx    <= '0;
				res_s66.hy    <= '0;
				res_s66.hz    <= '0;
				res_s66.ny    <= '0;
				res_s66.nz    <= '0;
				res_s66.fault <= nf_w.hit.fault;
			end else begin
				res_s66.t     <= nf_w.hit.t;
				res_s66.hx    <= nf_w.hit.hx;
				res_s66.hy    <= nf_w.hit.hy;
				res_s66.hz    <= nf_w.hit.hz;
				res_s66.fault <= FAULT_OK;
				if (root_s[NDIV_STEPS-1] == '0) begin
					res_s66.ny <= '0;
					res_s66.nz <= '0;
				end else begin
					res_s66.ny <= nf_w.hit.hy[31] ? $signed({1'b0, qy_s[NDIV_STEPS-1]})
						: $signed(32'(-{1'b0, qy_s[NDIV_STEPS-1]}));
					res_s66.nz <= $signed(32'(-{1'b0, qp_s[NDIV_STEPS-1]}));
				end
			end
		end
	end

	assign out_valid = v_s[NSTG-1];
	assign out_res   = res_s66;

endmodule

// ----- hw/rtl/ray_parabolic_cylinder_hit.sv -----
// Top level: ray against parabolic cylinder y^2 + 2pz = 0, fully pipelined
//
// Usage:
//  - ray (sink): one ray per beat, origin in Q16.16, direction in Q2.30.
//  - hit (source): one result beat per ray, in order: path length t and
//    hit point in Q16.16 (saturated), unit normal (ny, nz) in Q2.30 and a
//    fault code (discriminant negative, or no root at all).
//  - cfg_we / cfg_wdata: write the focal parameter p (Q16.16); write it
//    only while no ray is in flight.
//  - One ray is taken every cycle while no result beat stalls on the
//    output. The pipeline includes the 64 stage square root of the
//    discriminant, the 32 stage path length divider, the 32 stage square
//    root of the normal length and the 31 stage normal dividers.
//  - Reset clears every stage valid bit and loads p = 1.0; no clearing pass.
//  - A stalled hit beat holds the whole pipeline in place, and ray.ready
//    drops with it; an empty output stage keeps ray.ready high.
`timescale 1ns / 1ps
module ray_parabolic_cylinder_hit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata,
	rpch_ray_if.sink    ray,
	rpch_hit_if.source  hit
);
	import rpch_pkg::*;

	logic [30:0]  focal_q;
	logic         adv;
	ray_t         ray_w;

	logic         cf_valid, rt_valid, ph_valid, nm_valid;
	coef_t        cf_coef, rt_coef;
	logic [127:0] cf_disc;
	logic [63:0]  rt_root;
	hit_t         ph_hit;
	res_t         nm_res;

	// focal parameter register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RESET;
		end else if (cfg_we) begin
			focal_q <= cfg_wdata;
		end
	end

	// advance every stage unless a finished beat is waiting on the output
	assign adv       = !nm_valid || hit.ready;
	assign ray.ready = adv;

	assign ray_w.ox = ray.origin_x;
	assign ray_w.oy = ray.origin_y;
	assign ray_w.oz = ray.origin_z;
	assign ray_w.dx = ray.dir_x;
	assign ray_w.dy = ray.dir_y;
	assign ray_w.dz = ray.dir_z;

	// coefficients and discriminant
	rpch_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (ray.valid),
		.in_ray    (ray_w),
		.in_p      (focal_q),
		.out_valid (cf_valid),
		.out_coef  (cf_coef),
		.out_disc  (cf_disc)
	);

	// square root of the discriminant
	rpch_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (cf_valid),
		.in_coef   (cf_coef),
		.in_disc   (cf_disc),
		.out_valid (rt_valid),
		.out_coef  (rt_coef),
		.out_root  (rt_root)
	);

	// path length and hit point
	rpch_path u_path (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rt_valid),
		.in_coef   (rt_coef),
		.in_root   (rt_root),
		.out_valid (ph_valid),
		.out_hit   (ph_hit)
	);

	// surface normal and output register
	rpch_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (ph_valid),
		.in_hit    (ph_hit),
		.out_valid (nm_valid),
		.out_res   (nm_res)
	);

	assign hit.valid    = nm_valid;
	assign hit.path_len = nm_res.t;
	assign hit.hit_x    = nm_res.hx;
	assign hit.hit_y    = nm_res.hy;
	assign hit.hit_z    = nm_res.hz;
	assign hit.normal_y = nm_res.ny;
	assign hit.normal_z = nm_res.nz;
	assign hit.fault    = nm_res.fault;

endmodule

// ----- hw/rtl/rpch_check.sv -----
// Port level checks of the intersection block and their bind
`timescale 1ns / 1ps
module rpch_check (
	input logic        clk,
	input logic        arst_n,
	input logic        ray_ready,
	input logic        hit_valid,
	input logic        hit_ready,
	input logic [31:0] path_len,
	input logic [31:0] hit_x,
	input logic [31:0] hit_y,
	input logic [31:0] hit_z,
	input logic [31:0] normal_y,
	input logic [31:0] normal_z,
	input logic [1:0]  fault
);
	import rpch_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit_ready |=> hit_valid && $stable(path_len)
			&& $stable(hit_x) && $stable(hit_y) && $stable(hit_z)
			&& $stable(normal_y) && $stable(normal_z) && $stable(fault))
		else $error("stalled result beat changed");

	// ray side stalls exactly when a result waits on the output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ray_ready == (!hit_valid || hit_ready))
		else $error("input ready does not follow output stall");

	// a fault beat carries zeros in every other field
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && (fault == FAULT_NEG_DISC || fault == FAULT_NO_ROOT)
			|-> path_len == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0
			&& normal_y == '0 && normal_z == '0)
		else $error("fault beat with nonzero payload");

	// the normal points against +z for a positive focal parameter
	a_nz_sign: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && fault == FAULT_OK |-> normal_z[31] || normal_z == '0)
		else $error("normal z has wrong sign");

	// only the three defined fault codes leave the block
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid |-> fault == FAULT_OK || fault == FAULT_NEG_DISC
			|| fault == FAULT_NO_ROOT)
		else $error("undefined fault code");

endmodule

bind ray_parabolic_cylinder_hit rpch_check u_rpch_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.ray_ready (ray.ready),
	.hit_valid (hit.valid),
	.hit_ready (hit.ready),
	.path_len  (hit.path_len),
	.hit_x     (hit.hit_x),
	.hit_y     (hit.hit_y),
	.hit_z     (hit.hit_z),
	.normal_y  (hit.normal_y),
	.normal_z  (hit.normal_z),
	.fault     (hit.fault)
);

// ----- test/ray_parabolic_cylinder_hit_tb.sv -----
// Testbench: random and directed rays against the parabolic cylinder block, checked against a predictor
`timescale 1ns / 1ps
module ray_parabolic_cylinder_hit_tb;
	import rpch_pkg::*;

	// Latency of the pipeline; a margin is added where it serves as the settle pause.
	localparam int PIPE_DEPTH = 172;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [30:0] cfg_wdata;

	rpch_ray_if ray ();
	rpch_hit_if hit ();

	ray_parabolic_cylinder_hit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ray       (ray.sink),
		.hit       (hit.source)
	);

	// Testbench copy of the focal parameter, updated with each write.
	logic [30:0] focal_p;

	ray_t   pending_rays[$];
	res_t   expected_hits[$];
	int     error_count;
	int     rays_sent;
	int     hits_seen;
	int     fault_seen[3];
	int     configs_done;
	bit     stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -------------------------------------------------------------------------
	// Predictor helpers, all at 128-bit width where it matters.
	// -------------------------------------------------------------------------
	function automatic logic [63:0] sqrt_floor(logic [127:0] v);
		logic [63:0]  r;
		logic [63:0]  c;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (64'd1 << i);
			if ({64'd0, c} * {64'd0, c} <= v) r = c;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
		if (v > 128'sd2147483647) return INT32_MAX;
		if (v < -128'sd2147483648) return INT32_MIN;
		return v[31:0];
	endfunction

	// Floor of v / 2^30 for a signed product.
	function automatic logic signed [127:0] floor_shr30(logic signed [127:0] v);
		return v >>> 30;
	endfunction

	// Truncating signed divide by a positive magnitude.
	function automatic logic signed [127:0] div_trunc(logic signed [127:0] n,
		logic [127:0] d);
		logic [127:0] m;
		m = (n < 0) ? -n : n;
		m = m / d;
		return (n < 0) ? -$signed(m) : $signed(m);
	endfunction

	// Compute the expected hit for one ray under the given focal parameter.
	function automatic res_t trace_ray(ray_t r, logic [30:0] pp);
		res_t res;
		logic signed [127:0] ox, oy, oz, dx, dy, dz, p;
		logic signed [127:0] h, c, hy, t;
		logic [127:0] hmag, cmag, amag, disc, num, q, s, root;
		bit neg;
		ox = r.ox; oy = r.oy; oz = r.oz;
		dx = r.dx; dy = r.dy; dz = r.dz;
		p = $signed({97'd0, pp});
		res = '0;
		h = dz * p + dy * oy;
		c = oy * oy + 2 * (p * oz);
		hmag = (h < 0) ? -h : h;
		cmag = (c < 0) ? -c : c;
		amag = dy * dy;
		if (amag == 0) begin
			if (hmag == 0) begin
				res.fault = FAULT_NO_ROOT;
				return res;
			end
			num = cmag << 29;
			q = num / hmag;
			neg = ((c < 0) == (h < 0));
		end else begin
			if (c < 0) disc = hmag * hmag + amag * cmag;
			else if (hmag * hmag < amag * cmag) begin
				res.fault = FAULT_NEG_DISC;
				return res;
			end else disc = hmag * hmag - amag * cmag;
			s = sqrt_floor(disc);
			if (h < 0) begin
				num = s + hmag; neg = 0;
			end else if (s >= hmag) begin
				num = s - hmag; neg = 0;
			end else begin
				num = hmag - s; neg = 1;
			end
			q = (num << 30) / amag;
		end
		// Saturate the magnitude, then apply the sign.
		if (neg) t = (q >= 128'd2147483648) ? -128'sd2147483648 : -$signed(q);
		else     t = (q > 128'd2147483647) ? 128'sd2147483647 : $signed(q);
		res.t  = t[31:0];
		res.hx = clamp32(ox + floor_shr30(t * dx));
		res.hy = clamp32(oy + floor_shr30(t * dy));
		res.hz = clamp32(oz + floor_shr30(t * dz));
		hy = res.hy;
		root = sqrt_floor(hy * hy + p * p);
		if (root != 0) begin
			res.ny = 32'(-div_trunc(hy * 128'sd1073741824, root));
			res.nz = 32'(-div_trunc(p * 128'sd1073741824, root));
		end
		res.fault = FAULT_OK;
		return res;
	endfunction

	// -------------------------------------------------------------------------
	// Driver: bursts of beats with random gaps; payload comes from the queue.
	// -------------------------------------------------------------------------
	int burst_left;
	int gap_left;
	ray_t cur_ray;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray.valid    <= 1'b0;
			ray.origin_x <= '0;
			ray.origin_y <= '0;
			ray.origin_z <= '0;
			ray.dir_x    <= '0;
			ray.dir_y    <= '0;
			ray.dir_z    <= '0;
			burst_left   <= 0;
			gap_left     <= 0;
		end else begin
			// Hold while a beat is waiting for ready.
			if (!ray.valid || ray.ready) begin
				if (ray.valid) begin
					// beat accepted: predict it with the register as it stands now
					expected_hits.push_back(trace_ray(cur_ray, focal_p));
					rays_sent++;
				end
				if (gap_left > 0) begin
					gap_left  <= gap_left - 1;
					ray.valid <= 1'b0;
				end else if (pending_rays.size() > 0) begin
					cur_ray = pending_rays.pop_front();
					ray.valid    <= 1'b1;
					ray.origin_x <= cur_ray.ox;
					ray.origin_y <= cur_ray.oy;
					ray.origin_z <= cur_ray.oz;
					ray.dir_x    <= cur_ray.dx;
					ray.dir_y    <= cur_ray.dy;
					ray.dir_z    <= cur_ray.dz;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(40, 1);
						// some bursts run back to back, others leave a gap
						gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					ray.valid <= 1'b0;
				end
			end
		end
	end

	// -------------------------------------------------------------------------
	// Monitor: stall pattern on ready, compare each accepted beat.
	// -------------------------------------------------------------------------
	int stall_mode;
	int stall_phase;

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			hit.ready   <= 1'b0;
			stall_mode  <= 0;
			stall_phase <= 0;
		end else begin
			if (hit.valid && hit.ready) begin
				hits_seen++;
				if (expected_hits.size() == 0) begin
					$display("%0t: unexpected hit beat path_len=%0d fault=%0d",
						$time, hit.path_len, hit.fault);
					error_count++;
				end else begin
					want = expected_hits.pop_front();
					if (want.fault <= FAULT_NO_ROOT) fault_seen[want.fault]++;
					if (hit.path_len !== want.t || hit.hit_x !== want.hx ||
						hit.hit_y !== want.hy || hit.hit_z !== want.hz ||
						hit.normal_y !== want.ny || hit.normal_z !== want.nz ||
						hit.fault !== want.fault) begin
						$display("%0t: mismatch expected t=%0d x=%0d y=%0d z=%0d ny=%0d nz=%0d f=%0d",
							$time, want.t, want.hx, want.hy, want.hz, want.ny, want.nz,
							want.fault);
						$display("%0t:          actual   t=%0d x=%0d y=%0d z=%0d ny=%0d nz=%0d f=%0d",
							$time, hit.path_len, hit.hit_x, hit.hit_y, hit.hit_z,
							hit.normal_y, hit.normal_z, hit.fault);
						error_count++;
					end
				end
			end
			// Rotate through stretches: always ready, periodic stall, random stall.
			stall_phase <= stall_phase + 1;
			if (stall_phase % 300 == 299) stall_mode <= $urandom_range(2, 0);
			case (stall_mode)
				0: hit.ready <= 1'b1;
				1: hit.ready <= (stall_phase % 7) < 4;
				default: hit.ready <= $urandom_range(3, 0) != 0;
			endcase
		end
	end

	// -------------------------------------------------------------------------
	// Stimulus
	// -------------------------------------------------------------------------
	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5, 0))
			0: return INT32_MAX;
			1: return INT32_MIN;
			2: return 32'sd0;
			3: return $signed($urandom_range(32'h0002_0000, 0)) - 32'sh0001_0000;
			default: return $signed($urandom);
		endcase
	endfunction

	// Ray that usually hits: origin components under 8192 in magnitude, direction components under 1.0.
	function automatic ray_t rand_ray();
		ray_t r;
		if ($urandom_range(4, 0) == 0) begin
			r.ox = rand_word(); r.oy = rand_word(); r.oz = rand_word();
			r.dx = rand_word(); r.dy = rand_word(); r.dz = rand_word();
		end else begin
			r.ox = $signed($urandom) >>> $urandom_range(14, 2);
			r.oy = $signed($urandom) >>> $urandom_range(14, 4);
			r.oz = $signed($urandom) >>> $urandom_range(14, 4);
			r.dx = $signed($urandom) >>> $urandom_range(3, 1);
			r.dy = ($urandom_range(7, 0) == 0) ? 32'sd0 : ($signed($urandom) >>> 1);
			r.dz = $signed($urandom) >>> 1;
		end
		return r;
	endfunction

	function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
		ray_t r;
		r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
		return r;
	endfunction

	task automatic write_focal(logic [30:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		focal_p   = v;
		configs_done++;
	endtask

	// Wait until every queued ray is out and every result is back, then settle.
	task automatic drain();
		while (pending_rays.size() > 0 || ray.valid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
	endtask

	localparam int PHASES = 6;
	logic [30:0] focal_set[PHASES] = '{31'd65536, 31'd1, 31'h7FFF_FFFF,
		31'd131072, 31'd4096, 31'd65536};

	initial begin
		error_count  = 0;
		rays_sent    = 0;
		hits_seen    = 0;
		configs_done = 0;
		stim_done    = 0;
		fault_seen   = '{0, 0, 0};
		focal_p      = FOCAL_RESET;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		arst_n       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rays under the reset value of p.
		pending_rays.push_back(make_ray(0, 0, 0, 0, 32'h4000_0000, 0));          // through vertex
		pending_rays.push_back(make_ray(0, 0, -65536, 0, 0, 32'h4000_0000));     // linear root
		pending_rays.push_back(make_ray(5, 0, 0, 1, 0, 0));                      // no solution
		pending_rays.push_back(make_ray(0, 65536, 65536, 0, 32'h4000_0000, 0));  // negative discriminant
		pending_rays.push_back(make_ray(0, 32'sh0003_0000, -32'sh0001_0000, 0,
			-32'sh4000_0000, 0));                                              // hit in front of origin
		pending_rays.push_back(make_ray(INT32_MAX, INT32_MAX, INT32_MAX,
			INT32_MAX, INT32_MAX, INT32_MAX));
		pending_rays.push_back(make_ray(INT32_MIN, INT32_MIN, INT32_MIN,
			INT32_MIN, INT32_MIN, INT32_MIN));
		pending_rays.push_back(make_ray(INT32_MIN, INT32_MAX, 0, INT32_MAX, 1, INT32_MIN));
		pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1));
		pending_rays.push_back(make_ray(0, 0, INT32_MIN, 0, 0, 1));              // saturated t
		pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0));
		drain();

		// Random rays across several p settings, extremes included.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_focal(focal_set[ph]);
			for (int i = 0; i < 200; i++) pending_rays.push_back(rand_ray());
			drain();
		end
		// A random p value and a final mixed batch.
		write_focal(31'($urandom_range(32'h7FFF_FFFF, 1)));
		for (int i = 0; i < 40; i++) pending_rays.push_back(rand_ray());
		drain();

		$display("Covered %0d rays over %0d focal settings (ok %0d, neg disc %0d, no root %0d).",
			rays_sent, configs_done, fault_seen[0], fault_seen[1], fault_seen[2]);
		if (error_count == 0 && expected_hits.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: several times the slowest correct run.
	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
